FILE: hw/rtl/hrat_pkg.sv
// hrat_pkg: shared widths, register indexes, reset values and the
// controller/datapath command and status structs of the hot-row tracker.
// no dependencies
package hrat_pkg;

  localparam int BANK_IN_W  = 4;
  localparam int ROW_IN_W   = 16;
  localparam int CNT_OUT_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TE_W       = 7;
  localparam int THR_W      = 24;
  localparam int EPOCH_W    = 32;
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_TICKS    = CFG_IDX_W'(2);

  localparam logic [TE_W-1:0]    TE_RESET    = TE_W'(64);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1000);
  localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(64000000);

  localparam logic CMD_ACTIVATE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  typedef struct packed {
    logic load;
    logic tick_inc;
    logic scan_init;
    logic scan_step;
    logic apply;
    logic div_start;
    logic finish;
  } hrat_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic bank_ok;
    logic epoch_zero;
    logic scan_done;
    logic need_swap;
    logic div_done;
  } hrat_sts_t;

endpackage

FILE: hw/rtl/hot_row_activation_tracker.sv
// hot_row_activation_tracker: top level, configuration registers, controller
// and datapath. depends on hrat_pkg, hrat_ctrl, hrat_dp
//
//   channel  handshake                 payload
//   in_      start / busy              in_command, in_bank, in_row
//   out_     out_valid (strobe)        swap_needed, tracked, activation_count,
//                                      spilled, epoch_cleared
//   cfg_     cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one request at a time; busy is high from acceptance until the result strobe
// activation: scan of the bank's occupied slots (one slot read per cycle), then
// the threshold remainder when the row is tracked and the threshold is nonzero
// tick: 32-step remainder against epoch_ticks, skipped when epoch is zero
// synchronous reset clears fill counts, spillover and tick counters at once
// the result strobe lasts one cycle and cannot be held off
module hot_row_activation_tracker import hrat_pkg::*; #(
  parameter int NUM_BANKS   = 16,
  parameter int MAX_ENTRIES = 64,
  parameter int ROW_BITS    = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [BANK_IN_W-1:0]  in_bank,
  input  logic [ROW_IN_W-1:0]   in_row,
  output logic                  out_valid,
  output logic                  out_swap_needed,
  output logic                  out_tracked,
  output logic [CNT_OUT_W-1:0]  out_activation_count,
  output logic                  out_spilled,
  output logic                  out_epoch_cleared,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TE_W-1:0]    table_entries_r;
  logic [THR_W-1:0]   swap_threshold_r;
  logic [EPOCH_W-1:0] epoch_ticks_r;
  hrat_cmd_t          cmd;
  hrat_sts_t          sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_entries_r  <= TE_RESET;
      swap_threshold_r <= THR_RESET;
      epoch_ticks_r    <= EPOCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TABLE_ENTRIES:  table_entries_r  <= cfg_data[TE_W-1:0];
        CFG_SWAP_THRESHOLD: swap_threshold_r <= cfg_data[THR_W-1:0];
        CFG_EPOCH_TICKS:    epoch_ticks_r    <= cfg_data[EPOCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hrat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  hrat_dp #(
    .NUM_BANKS   (NUM_BANKS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .ROW_BITS    (ROW_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_command     (in_command),
    .in_bank        (in_bank),
    .in_row         (in_row),
    .table_entries  (table_entries_r),
    .swap_threshold (swap_threshold_r),
    .epoch_ticks    (epoch_ticks_r),
    .res_swap       (out_swap_needed),
    .res_tracked    (out_tracked),
    .res_count      (out_activation_count),
    .res_spilled    (out_spilled),
    .res_cleared    (out_epoch_cleared)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a request");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_track_spill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tracked && out_spilled))
    else $error("row both tracked and spilled");

  a_clear_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_epoch_cleared) |-> (!out_tracked && !out_swap_needed && !out_spilled))
    else $error("clear flagged on an activation result");

  a_untracked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tracked) |-> (out_activation_count == '0 && !out_swap_needed))
    else $error("untracked row carries a count or swap request");

endmodule

FILE: hw/rtl/hrat_div.sv
// hrat_div: iterative restoring remainder unit, one quotient bit per cycle.
// depends on hrat_pkg
module hrat_div import hrat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic             rem_zero
);

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvd_r;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W:0]       trial;

  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
    end
  end

  assign done     = (cnt_r == '0);
  assign rem_zero = (rem_r == '0);

endmodule

FILE: hw/rtl/hrat_dp.sv
// hrat_dp: slot memories, per-bank fill and spillover counters, tick counter,
// slot scan, update decision, result registers. depends on hrat_pkg, hrat_div
module hrat_dp import hrat_pkg::*; #(
  parameter int NUM_BANKS   = 16,
  parameter int MAX_ENTRIES = 64,
  parameter int ROW_BITS    = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hrat_cmd_t            cmd,
  output hrat_sts_t            sts,
  input  logic                 in_command,
  input  logic [BANK_IN_W-1:0] in_bank,
  input  logic [ROW_IN_W-1:0]  in_row,
  input  logic [TE_W-1:0]      table_entries,
  input  logic [THR_W-1:0]     swap_threshold,
  input  logic [EPOCH_W-1:0]   epoch_ticks,
  output logic                 res_swap,
  output logic                 res_tracked,
  output logic [CNT_OUT_W-1:0] res_count,
  output logic                 res_spilled,
  output logic                 res_cleared
);

  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH  = NUM_BANKS * MAX_ENTRIES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // request fields
  logic                  cmd_tick_r;
  logic                  bank_ok_r;
  logic [BANK_W-1:0]     bank_r;
  logic [ROW_BITS-1:0]   row_r;
  logic [31:0]           bank_wide, row_wide;

  // tracking state
  logic [FILL_W-1:0]     fill_r  [NUM_BANKS];
  logic [COUNT_BITS-1:0] spill_r [NUM_BANKS];
  logic [EPOCH_W-1:0]    tick_r;
  logic [ROW_BITS-1:0]   mem_row [DEPTH];
  logic [COUNT_BITS-1:0] mem_cnt [DEPTH];

  // scan
  logic [FILL_W-1:0]     idx_r;
  logic                  rd_vld_r;
  logic [FILL_W-1:0]     rd_slot_r;
  logic [ROW_BITS-1:0]   rd_row_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;
  logic                  hit_vld_r, match_vld_r;
  logic [FILL_W-1:0]     hit_slot_r, match_slot_r;
  logic [COUNT_BITS-1:0] hit_cnt_r;

  // results
  logic                  res_swap_r, res_tracked_r, res_spilled_r, res_cleared_r;
  logic [COUNT_BITS-1:0] res_cnt_r;
  logic [31:0]           cnt_wide;

  logic [FILL_W-1:0]     cur_fill;
  logic [COUNT_BITS-1:0] cur_spill;
  logic [31:0]           lim32;
  logic                  can_insert;
  logic                  sel_hit, sel_ins, sel_rep, sel_spill;
  logic [COUNT_BITS-1:0] hit_inc, spill_inc, new_cnt;
  logic [FILL_W-1:0]     wslot;
  logic [ADDR_W-1:0]     base_addr, raddr, waddr;
  logic                  mem_re, mem_we;
  logic                  epoch_clear;
  logic [DIV_W-1:0]      div_dividend, div_divisor;
  logic                  div_done, div_rem_zero;

  assign bank_wide = 32'(in_bank);
  assign row_wide  = 32'(in_row);

  assign cur_fill  = fill_r[bank_r];
  assign cur_spill = spill_r[bank_r];
  assign lim32     = (32'(table_entries) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES)
                                                              : 32'(table_entries);
  assign can_insert = (32'(cur_fill) < lim32) && (32'(cur_fill) < 32'(MAX_ENTRIES));

  assign hit_inc   = (hit_cnt_r == CNT_MAX) ? hit_cnt_r : hit_cnt_r + COUNT_BITS'(1);
  assign spill_inc = (cur_spill == CNT_MAX) ? cur_spill : cur_spill + COUNT_BITS'(1);

  assign sel_hit   = hit_vld_r;
  assign sel_ins   = !hit_vld_r && can_insert;
  assign sel_rep   = !hit_vld_r && !can_insert && match_vld_r;
  assign sel_spill = !hit_vld_r && !can_insert && !match_vld_r;

  always_comb begin
    if (sel_hit) begin
      new_cnt = hit_inc;
      wslot   = hit_slot_r;
    end else if (sel_ins) begin
      new_cnt = COUNT_BITS'(1);
      wslot   = cur_fill;
    end else begin
      new_cnt = spill_inc;
      wslot   = match_slot_r;
    end
  end

  assign base_addr = ADDR_W'(ADDR_W'(bank_r) * ADDR_W'(MAX_ENTRIES));
  assign raddr     = ADDR_W'(base_addr + ADDR_W'(idx_r));
  assign waddr     = ADDR_W'(base_addr + ADDR_W'(wslot));
  assign mem_re    = cmd.scan_step && (idx_r < cur_fill);
  assign mem_we    = cmd.apply && !sel_spill;

  assign epoch_clear = cmd.finish && cmd_tick_r && div_rem_zero;

  // slot memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_row[waddr] <= row_r;
      mem_cnt[waddr] <= new_cnt;
    end
    if (mem_re) begin
      rd_row_r <= mem_row[raddr];
      rd_cnt_r <= mem_cnt[raddr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_tick_r <= in_command;
      bank_ok_r  <= (bank_wide < 32'(NUM_BANKS));
      bank_r     <= bank_wide[BANK_W-1:0];
      row_r      <= row_wide[ROW_BITS-1:0];
    end
  end

  // fill counts, spillover counters, tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        fill_r[i]  <= '0;
        spill_r[i] <= '0;
      end
      tick_r <= '0;
    end else begin
      if (cmd.tick_inc) begin
        tick_r <= tick_r + EPOCH_W'(1);
      end
      if (epoch_clear) begin
        for (int i = 0; i < NUM_BANKS; i++) begin
          fill_r[i]  <= '0;
          spill_r[i] <= '0;
        end
      end else if (cmd.apply) begin
        if (sel_ins) begin
          fill_r[bank_r] <= cur_fill + FILL_W'(1);
        end
        if (sel_spill) begin
          spill_r[bank_r] <= spill_inc;
        end
      end
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_vld_r   <= 1'b0;
      match_vld_r <= 1'b0;
    end else if (cmd.scan_init) begin
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_vld_r   <= 1'b0;
      match_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_vld_r <= mem_re;
      if (mem_re) begin
        idx_r <= idx_r + FILL_W'(1);
      end
      if (rd_vld_r) begin
        if (!hit_vld_r && rd_row_r == row_r) begin
          hit_vld_r <= 1'b1;
        end
        if (!match_vld_r && rd_cnt_r == cur_spill) begin
          match_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      if (mem_re) begin
        rd_slot_r <= idx_r;
      end
      if (rd_vld_r) begin
        if (!hit_vld_r && rd_row_r == row_r) begin
          hit_slot_r <= rd_slot_r;
          hit_cnt_r  <= rd_cnt_r;
        end
        if (!match_vld_r && rd_cnt_r == cur_spill) begin
          match_slot_r <= rd_slot_r;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_swap_r    <= 1'b0;
      res_tracked_r <= 1'b0;
      res_cnt_r     <= '0;
      res_spilled_r <= 1'b0;
      res_cleared_r <= 1'b0;
    end else if (cmd.apply) begin
      res_tracked_r <= !sel_spill;
      res_spilled_r <= sel_spill;
      res_cnt_r     <= sel_spill ? '0 : new_cnt;
    end else if (cmd.finish) begin
      if (cmd_tick_r) begin
        res_cleared_r <= div_rem_zero;
      end else begin
        res_swap_r <= div_rem_zero;
      end
    end
  end

  assign div_dividend = cmd_tick_r ? tick_r + EPOCH_W'(1) : DIV_W'(res_cnt_r);
  assign div_divisor  = cmd_tick_r ? epoch_ticks : DIV_W'(swap_threshold);

  hrat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem_zero (div_rem_zero)
  );

  assign sts.is_tick    = cmd_tick_r;
  assign sts.bank_ok    = bank_ok_r;
  assign sts.epoch_zero = (epoch_ticks == '0);
  assign sts.scan_done  = !(idx_r < cur_fill) && !rd_vld_r;
  assign sts.need_swap  = res_tracked_r && (swap_threshold != '0);
  assign sts.div_done   = div_done;

  assign cnt_wide    = 32'(res_cnt_r);
  assign res_swap    = res_swap_r;
  assign res_tracked = res_tracked_r;
  assign res_count   = cnt_wide[CNT_OUT_W-1:0];
  assign res_spilled = res_spilled_r;
  assign res_cleared = res_cleared_r;

endmodule

FILE: hw/rtl/hrat_ctrl.sv
// hrat_ctrl: sequencing state machine for one request at a time.
// depends on hrat_pkg
module hrat_ctrl import hrat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  hrat_sts_t sts,
  output hrat_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_APPLY    = 3'd3;
  localparam logic [2:0] S_POST     = 3'd4;
  localparam logic [2:0] S_DIV      = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_tick) begin
          cmd.tick_inc = 1'b1;
          if (sts.epoch_zero) begin
            state_nxt = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else if (!sts.bank_ok) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_APPLY;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (sts.need_swap) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

FILE: sim/hrat_checker.sv
// hrat_checker: watches the request, result and register channels of the
// hot-row tracker, predicts each result and compares it field by field.
// depends on hrat_pkg
module hrat_checker import hrat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_command,
  input  logic [BANK_IN_W-1:0]  in_bank,
  input  logic [ROW_IN_W-1:0]   in_row,
  input  logic                  out_valid,
  input  logic                  out_swap_needed,
  input  logic                  out_tracked,
  input  logic [CNT_OUT_W-1:0]  out_activation_count,
  input  logic                  out_spilled,
  input  logic                  out_epoch_cleared,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam int BANKS = 16;
  localparam int SLOTS = 64;

  typedef struct packed {
    logic                 swap_needed;
    logic                 tracked;
    logic [CNT_OUT_W-1:0] activation_count;
    logic                 spilled;
    logic                 epoch_cleared;
  } tracker_result_t;

  logic                 slot_live  [BANKS][SLOTS];
  logic [ROW_IN_W-1:0]  slot_row   [BANKS][SLOTS];
  logic [CNT_OUT_W-1:0] slot_hits  [BANKS][SLOTS];
  logic [CNT_OUT_W-1:0] spill_hits [BANKS];
  logic [EPOCH_W-1:0]   tick_total;
  logic [TE_W-1:0]      table_size;
  logic [THR_W-1:0]     threshold;
  logic [EPOCH_W-1:0]   epoch_len;

  tracker_result_t expected_outcomes [$];
  tracker_result_t oldest;

  function automatic logic [CNT_OUT_W-1:0] sat_inc(input logic [CNT_OUT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_tables();
    foreach (slot_live[b, s]) slot_live[b][s] = 1'b0;
    foreach (spill_hits[b]) spill_hits[b] = '0;
  endfunction

  function automatic tracker_result_t update_tracker(input logic cmd,
                                                    input logic [BANK_IN_W-1:0] bank,
                                                    input logic [ROW_IN_W-1:0] row);
    tracker_result_t r;
    int limit;
    int used;
    int hit;
    int free_slot;
    int victim;
    r = '0;
    used = 0;
    hit = -1;
    free_slot = -1;
    victim = -1;
    if (cmd == CMD_TICK) begin
      tick_total = tick_total + 1'b1;
      if (epoch_len != 0 && (tick_total % epoch_len) == 0) begin
        clear_tables();
        r.epoch_cleared = 1'b1;
      end
      return r;
    end
    limit = (table_size > SLOTS) ? SLOTS : int'(table_size);
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_live[bank][s]) begin
        used++;
        if (hit < 0 && slot_row[bank][s] == row) hit = s;
        if (victim < 0 && slot_hits[bank][s] == spill_hits[bank]) victim = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (hit >= 0) begin
      slot_hits[bank][hit] = sat_inc(slot_hits[bank][hit]);
      r.activation_count = slot_hits[bank][hit];
      r.tracked = 1'b1;
    end else if (used < limit && free_slot >= 0) begin
      slot_live[bank][free_slot] = 1'b1;
      slot_row[bank][free_slot] = row;
      slot_hits[bank][free_slot] = 1;
      r.activation_count = 1;
      r.tracked = 1'b1;
    end else if (victim >= 0) begin
      slot_row[bank][victim] = row;
      slot_hits[bank][victim] = sat_inc(spill_hits[bank]);
      r.activation_count = slot_hits[bank][victim];
      r.tracked = 1'b1;
    end else begin
      spill_hits[bank] = sat_inc(spill_hits[bank]);
      r.spilled = 1'b1;
    end
    if (r.tracked && threshold != 0 && (r.activation_count % threshold) == 0)
      r.swap_needed = 1'b1;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tables();
      tick_total = '0;
      table_size = TE_RESET;
      threshold = THR_RESET;
      epoch_len = EPOCH_RESET;
      expected_outcomes.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TABLE_ENTRIES:  table_size = cfg_data[TE_W-1:0];
          CFG_SWAP_THRESHOLD: threshold = cfg_data[THR_W-1:0];
          CFG_EPOCH_TICKS:    epoch_len = cfg_data[EPOCH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, expected none, actual %0b %0b %0h %0b %0b",
                   $time, out_swap_needed, out_tracked, out_activation_count, out_spilled,
                   out_epoch_cleared);
        end else begin
          oldest = expected_outcomes.pop_front();
          check_field("swap_needed", oldest.swap_needed, out_swap_needed);
          check_field("tracked", oldest.tracked, out_tracked);
          check_field("activation_count", oldest.activation_count, out_activation_count);
          check_field("spilled", oldest.spilled, out_spilled);
          check_field("epoch_cleared", oldest.epoch_cleared, out_epoch_cleared);
        end
      end
      if (start && !busy)
        expected_outcomes.push_back(update_tracker(in_command, in_bank, in_row));
    end
    pending = expected_outcomes.size();
  end

endmodule

FILE: sim/tb.sv
// tb: drives requests and register writes into the hot-row tracker and gives
// the verdict. depends on hrat_pkg, hot_row_activation_tracker, hrat_checker
module tb import hrat_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_command;
  logic [BANK_IN_W-1:0]  in_bank;
  logic [ROW_IN_W-1:0]   in_row;
  logic                  out_valid;
  logic                  out_swap_needed;
  logic                  out_tracked;
  logic [CNT_OUT_W-1:0]  out_activation_count;
  logic                  out_spilled;
  logic                  out_epoch_cleared;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    errors;
  int                    pending;
  bit                    idle_on;
  int                    pool_size;
  logic [ROW_IN_W-1:0]   row_pool [24];
  logic [BANK_IN_W-1:0]  hot_bank [2];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  hot_row_activation_tracker i_dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_bank, .in_row,
    .out_valid, .out_swap_needed, .out_tracked, .out_activation_count,
    .out_spilled, .out_epoch_cleared,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  hrat_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_command, .in_bank, .in_row,
    .out_valid, .out_swap_needed, .out_tracked, .out_activation_count,
    .out_spilled, .out_epoch_cleared,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  task automatic issue(input logic cmd, input logic [BANK_IN_W-1:0] bank,
                       input logic [ROW_IN_W-1:0] row);
    int gap;
    bit hold;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    hold = idle_on && ($urandom_range(0, 3) == 0);
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_bank <= bank;
    in_row <= row;
    do @(posedge clk); while (busy);
    if (gap > 0 || hold) begin
      @(negedge clk);
      start <= 1'b0;
      if (hold) while (busy) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
  endtask

  // registers change only with no request in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_tracker(input logic [CFG_DATA_W-1:0] entries,
                                 input logic [CFG_DATA_W-1:0] thr,
                                 input logic [CFG_DATA_W-1:0] ticks);
    write_reg(CFG_TABLE_ENTRIES, entries);
    write_reg(CFG_SWAP_THRESHOLD, thr);
    write_reg(CFG_EPOCH_TICKS, ticks);
  endtask

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [TE_W-1:0]    te;
    logic [THR_W-1:0]   thr;
    logic [EPOCH_W-1:0] ep;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ACTIVATE;
    in_bank = '0;
    in_row = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TABLE_ENTRIES;
    cfg_data = '0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // insert, hit, far corners of bank and row
    issue(CMD_ACTIVATE, 4'h0, 16'h0000);
    issue(CMD_ACTIVATE, 4'h0, 16'h0000);
    issue(CMD_ACTIVATE, 4'hF, 16'hFFFF);
    issue(CMD_TICK, 4'hF, 16'hFFFF);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);

    // one-entry table: spill, replace, swap on every count, clear on third tick
    program_tracker(32'd1, 32'd1, 32'd3);
    issue(CMD_ACTIVATE, 4'h3, 16'h1234);
    issue(CMD_ACTIVATE, 4'h3, 16'h5678);
    issue(CMD_ACTIVATE, 4'h3, 16'h9ABC);
    issue(CMD_ACTIVATE, 4'h3, 16'h9ABC);
    issue(CMD_TICK, 4'h0, 16'h0000);
    issue(CMD_TICK, 4'h0, 16'h0000);
    issue(CMD_ACTIVATE, 4'h3, 16'h5678);

    // table filled to three of four entries, then shrunk to size zero below its fill
    program_tracker(32'd4, 32'h00FF_FFFF, 32'd0);
    issue(CMD_ACTIVATE, 4'h7, 16'h0001);
    issue(CMD_ACTIVATE, 4'h7, 16'h0002);
    issue(CMD_ACTIVATE, 4'h7, 16'h0003);
    issue(CMD_ACTIVATE, 4'h7, 16'h0001);
    write_reg(CFG_TABLE_ENTRIES, 32'd0);
    issue(CMD_ACTIVATE, 4'h7, 16'h0002);
    issue(CMD_ACTIVATE, 4'h7, 16'hAAAA);
    issue(CMD_ACTIVATE, 4'h7, 16'h5555);

    // oversized table, no swaps, clear on each tick while epoch is one, then no clear
    program_tracker(32'd127, 32'd0, 32'd1);
    issue(CMD_ACTIVATE, 4'h9, 16'h8001);
    issue(CMD_TICK, 4'h9, 16'h8001);
    issue(CMD_ACTIVATE, 4'h7, 16'h0001);
    write_reg(CFG_EPOCH_TICKS, 32'hFFFF_FFFF);
    issue(CMD_TICK, 4'h0, 16'h0000);

    for (int phase = 0; phase < 16; phase++) begin
      case ($urandom_range(0, 6))
        0: te = 0;
        1: te = 1;
        2: te = 2;
        3: te = 3;
        4: te = TE_W'($urandom_range(4, 16));
        5: te = 64;
        default: te = TE_W'($urandom_range(65, 127));
      endcase
      case ($urandom_range(0, 4))
        0: thr = 0;
        1: thr = 1;
        2: thr = THR_W'($urandom_range(2, 6));
        3: thr = '1;
        default: thr = THR_W'($urandom_range(7, 40));
      endcase
      case ($urandom_range(0, 4))
        0: ep = 0;
        1: ep = 1;
        2: ep = EPOCH_W'($urandom_range(2, 40));
        3: ep = '1;
        default: ep = $urandom();
      endcase
      program_tracker(($urandom() & ~32'h7F) | 32'(te),
                      ($urandom() & 32'hFF00_0000) | 32'(thr), 32'(ep));
      idle_on = ($urandom_range(0, 3) != 0);
      pool_size = $urandom_range(2, 24);
      foreach (row_pool[i]) row_pool[i] = ROW_IN_W'($urandom());
      hot_bank[0] = BANK_IN_W'($urandom());
      hot_bank[1] = BANK_IN_W'($urandom());
      for (int n = 0; n < 96; n++) begin
        if ($urandom_range(0, 9) == 0)
          issue(CMD_TICK, BANK_IN_W'($urandom()), ROW_IN_W'($urandom()));
        else
          issue(CMD_ACTIVATE,
                ($urandom_range(0, 9) < 7) ? hot_bank[$urandom_range(0, 1)]
                                           : BANK_IN_W'($urandom()),
                ($urandom_range(0, 19) < 17) ? row_pool[$urandom_range(0, pool_size - 1)]
                                             : ROW_IN_W'($urandom()));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: hot_row_activation_tracker.f
hw/rtl/hrat_pkg.sv
hw/rtl/hrat_div.sv
hw/rtl/hrat_dp.sv
hw/rtl/hrat_ctrl.sv
hw/rtl/hot_row_activation_tracker.sv
sim/hrat_checker.sv
sim/tb.sv
